>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL. Empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

>>> rtl/lcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_pkg
// Widths, register codes and shared types of the cap state classifier.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int TARE_BITS      = 24;
    localparam int WEIGHT_BITS    = 16;
    localparam int MARGIN_BITS    = 10;
    localparam int SMOOTH_BITS    = 26;
    localparam int SCALED_BITS    = 19;
    localparam int COMBO_BITS     = 3;
    localparam int NUM_COMBOS     = 1 << COMBO_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    // raw = sample - tare
    localparam int RAW_BITS = ((SAMPLE_BITS > TARE_BITS) ? SAMPLE_BITS : TARE_BITS) + 1;
    // 85*s + 15*raw
    localparam int ACC_BITS = ((SMOOTH_BITS + 7 > RAW_BITS + 4) ?
                               (SMOOTH_BITS + 7) : (RAW_BITS + 4)) + 1;

    // Truncating divide by 100: drop two bits, then multiply by ceil(2^k / 25).
    localparam int QX_BITS     = ACC_BITS - 2;
    localparam int RECIP_SHIFT = QX_BITS + 5;
    localparam int RECIP_BITS  = RECIP_SHIFT - 4;
    localparam int PROD_BITS   = QX_BITS + RECIP_BITS;
    localparam logic [63:0] RECIP_WIDE = ((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25;
    localparam logic [RECIP_BITS-1:0] RECIP25 = RECIP_WIDE[RECIP_BITS-1:0];

    // Window bounds: -(sum of three weights) -/+ margin
    localparam int BOUND_BITS = WEIGHT_BITS + 4;

    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(20);
    localparam logic [COMBO_BITS-1:0]  ALL_ON       = '0;
    localparam logic [COMBO_BITS-1:0]  ALL_REMOVED  = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TARE   = 3'd0,
        REG_CAP1   = 3'd1,
        REG_CAP2   = 3'd2,
        REG_CAP3   = 3'd3,
        REG_MARGIN = 3'd4
    } lcc_reg_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] cap1;
        logic [WEIGHT_BITS-1:0] cap2;
        logic [WEIGHT_BITS-1:0] cap3;
        logic [MARGIN_BITS-1:0] margin;
    } lcc_weights_t;

    typedef struct packed {
        logic                  found;
        logic [COMBO_BITS-1:0] combo;
    } lcc_match_t;

endpackage

>>> rtl/lcc_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_channels
// Valid/ready channels: sample input, result output and register writes.
// ----------------------------------------------------------------------------
interface lcc_sample_if;
    import lcc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface lcc_result_if;
    import lcc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SCALED_BITS-1:0] scaled_delta;
    logic                          match_found;
    logic [COMBO_BITS-1:0]         matched_combo;
    logic                          state_changed;
    logic [COMBO_BITS-1:0]         held_combo;
    logic [COMBO_BITS-1:0]         cap_led_mask;
    logic [COMBO_BITS-1:0]         track_play_mask;
    logic                          special_mode;
    logic                          rewind_pulse;

    modport source (output valid, output scaled_delta, output match_found,
                    output matched_combo, output state_changed, output held_combo,
                    output cap_led_mask, output track_play_mask, output special_mode,
                    output rewind_pulse, input ready);
    modport sink   (input valid, input scaled_delta, input match_found,
                    input matched_combo, input state_changed, input held_combo,
                    input cap_led_mask, input track_play_mask, input special_mode,
                    input rewind_pulse, output ready);
endinterface

interface lcc_cfg_if;
    import lcc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/load_cell_cap_state_classifier.sv
`timescale 1ns / 1ps
// Path: a sample accepted passes the tare, smoothing, scaling and result
// registers in that order; a stall on result.ready can hold it between them.
// Throughput: one sample per cycle unless result.ready stalls; the smoothing
// recurrence loop is a constant 85/15 sum plus one reciprocal multiply.
// Reset: rst_n clears the filter state to zero, the held combination to all
// caps on, the registers to zero with a margin of 20, and empties the pipe.
// ----------------------------------------------------------------------------
// load_cell_cap_state_classifier
// Tares and smooths load-cell samples, matches them to cap removal
// combinations and tracks the held cap state with LED and track outputs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module load_cell_cap_state_classifier (
    input  logic   clk,
    input  logic   rst_n,
    lcc_sample_if.sink   sample,
    lcc_result_if.source result,
    lcc_cfg_if.sink      cfg
);
    import lcc_pkg::*;

    logic signed [TARE_BITS-1:0]   tare_reg;
    logic [WEIGHT_BITS-1:0]        cap1_reg, cap2_reg, cap3_reg;
    logic [MARGIN_BITS-1:0]        margin_reg;
    lcc_weights_t                  weights;

    logic                          smo_valid, smo_ready;
    logic signed [SCALED_BITS-1:0] smo_delta;
    lcc_match_t                    match;

    logic                          out_valid_reg;
    logic                          load_out;
    logic [COMBO_BITS-1:0]         held_reg, held_next;
    logic                          changed_next;
    logic signed [SCALED_BITS-1:0] delta_out_reg;
    logic                          found_out_reg;
    logic [COMBO_BITS-1:0]         combo_out_reg;
    logic                          changed_out_reg;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg   <= '0;
            cap1_reg   <= '0;
            cap2_reg   <= '0;
            cap3_reg   <= '0;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_TARE:   tare_reg   <= cfg.data[TARE_BITS-1:0];
                REG_CAP1:   cap1_reg   <= cfg.data[WEIGHT_BITS-1:0];
                REG_CAP2:   cap2_reg   <= cfg.data[WEIGHT_BITS-1:0];
                REG_CAP3:   cap3_reg   <= cfg.data[WEIGHT_BITS-1:0];
                REG_MARGIN: margin_reg <= cfg.data[MARGIN_BITS-1:0];
                default:    ;
            endcase
        end
    end

    assign weights = '{cap1: cap1_reg, cap2: cap2_reg, cap3: cap3_reg, margin: margin_reg};

    lcc_smoother u_smoother (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sample.valid),
        .in_ready     (sample.ready),
        .sample_value (sample.sample_value),
        .tare_offset  (tare_reg),
        .out_valid    (smo_valid),
        .out_ready    (smo_ready),
        .scaled_delta (smo_delta)
    );

    lcc_matcher u_matcher (
        .clk          (clk),
        .weights      (weights),
        .scaled_delta (smo_delta),
        .match        (match)
    );

    // Result register: load when empty or while the old result transfers
    assign smo_ready = !out_valid_reg || result.ready;
    assign load_out  = smo_valid && smo_ready;

    always_comb
    begin
        changed_next = match.found && (match.combo != held_reg);
        held_next    = changed_next ? match.combo : held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= ALL_ON;
        end
        else
        begin
            if (smo_ready)
                out_valid_reg <= smo_valid;
            if (load_out)
                held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            delta_out_reg   <= smo_delta;
            found_out_reg   <= match.found;
            combo_out_reg   <= match.combo;
            changed_out_reg <= changed_next;
        end
    end

    // held_reg moves only with a result load, so it always matches the result
    assign result.valid           = out_valid_reg;
    assign result.scaled_delta    = delta_out_reg;
    assign result.match_found     = found_out_reg;
    assign result.matched_combo   = combo_out_reg;
    assign result.state_changed   = changed_out_reg;
    assign result.held_combo      = held_reg;
    assign result.cap_led_mask    = ~held_reg;
    assign result.track_play_mask = (held_reg == ALL_REMOVED) ? ALL_ON : held_reg;
    assign result.special_mode    = (held_reg == ALL_REMOVED);
    assign result.rewind_pulse    = changed_out_reg && (held_reg == ALL_ON);

    `ASSERT_NEXT(a_held_hold, clk, rst_n, !load_out, $stable(held_reg), "held combination moved without a result")
    `ASSERT_CLK(a_change_match, clk, rst_n, result.valid && result.state_changed |-> result.match_found && result.matched_combo == result.held_combo, "change without matching combination")
    `ASSERT_CLK(a_nomatch_zero, clk, rst_n, result.valid && !result.match_found |-> result.matched_combo == ALL_ON && !result.state_changed, "no match but combo or change set")

endmodule

>>> rtl/lcc_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_smoother
// Three-stage pipe: tare removal, 85/15 smoothing, scaling to display units.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcc_smoother (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [lcc_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic signed [lcc_pkg::TARE_BITS-1:0]   tare_offset,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [lcc_pkg::SCALED_BITS-1:0] scaled_delta
);
    import lcc_pkg::*;

    localparam logic signed [ACC_BITS-1:0] SMOOTH_HI = ACC_BITS'(2**(SMOOTH_BITS-1) - 1);
    localparam logic signed [ACC_BITS-1:0] SMOOTH_LO = ACC_BITS'(-(2**(SMOOTH_BITS-1)));
    localparam logic signed [ACC_BITS-1:0] SCALED_HI = ACC_BITS'(2**(SCALED_BITS-1) - 1);
    localparam logic signed [ACC_BITS-1:0] SCALED_LO = ACC_BITS'(-(2**(SCALED_BITS-1)));

    // Divide by 100, truncating toward zero, on the magnitude.
    function automatic logic signed [ACC_BITS-1:0] div100(
        input logic signed [ACC_BITS-1:0] v
    );
        logic                 neg;
        logic [ACC_BITS-1:0]  mag;
        logic [PROD_BITS-1:0] prod;
        logic [ACC_BITS-1:0]  q;
        neg  = v[ACC_BITS-1];
        mag  = neg ? ACC_BITS'(-v) : ACC_BITS'(v);
        prod = PROD_BITS'(mag[ACC_BITS-1:2]) * PROD_BITS'(RECIP25);
        q    = ACC_BITS'(prod >> RECIP_SHIFT);
        return neg ? -signed'(q) : signed'(q);
    endfunction

    logic                          v1_reg, v2_reg, v3_reg;
    logic                          rdy1, rdy2, rdy3;
    logic                          load1, load2, load3;
    logic signed [RAW_BITS-1:0]    raw_reg, raw_next;
    logic signed [SMOOTH_BITS-1:0] smooth_reg, smooth_next;
    logic signed [SCALED_BITS-1:0] delta_reg, delta_next;
    logic signed [ACC_BITS-1:0]    s_ext, r_ext, acc, q_smooth, q_scaled;

    assign rdy3  = !v3_reg || out_ready;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign load1 = in_valid && rdy1;
    assign load2 = v1_reg && rdy2;
    assign load3 = v2_reg && rdy3;

    assign in_ready     = rdy1;
    assign out_valid    = v3_reg;
    assign scaled_delta = delta_reg;

    always_comb
    begin
        raw_next = RAW_BITS'(sample_value) - RAW_BITS'(tare_offset);

        // 85 = 64 + 16 + 4 + 1, 15 = 16 - 1
        s_ext = ACC_BITS'(smooth_reg);
        r_ext = ACC_BITS'(raw_reg);
        acc   = (s_ext <<< 6) + (s_ext <<< 4) + (s_ext <<< 2) + s_ext
              + (r_ext <<< 4) - r_ext;

        q_smooth = div100(acc);
        if (q_smooth > SMOOTH_HI)
            smooth_next = SMOOTH_BITS'(SMOOTH_HI);
        else if (q_smooth < SMOOTH_LO)
            smooth_next = SMOOTH_BITS'(SMOOTH_LO);
        else
            smooth_next = SMOOTH_BITS'(q_smooth);

        q_scaled = div100(ACC_BITS'(smooth_reg));
        if (q_scaled > SCALED_HI)
            delta_next = SCALED_BITS'(SCALED_HI);
        else if (q_scaled < SCALED_LO)
            delta_next = SCALED_BITS'(SCALED_LO);
        else
            delta_next = SCALED_BITS'(q_scaled);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            smooth_reg <= '0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            // smoothed weight is the filter state: advance once per sample
            if (load2)
                smooth_reg <= smooth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
            raw_reg <= raw_next;
        if (load3)
            delta_reg <= delta_next;
    end

    `ASSERT_NEXT(a_smooth_hold, clk, rst_n, !load2, $stable(smooth_reg), "smooth state moved without a sample")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, v3_reg && !out_ready, v3_reg && $stable(delta_reg), "stalled delta lost")
    `ASSERT_CLK(a_bubble_ready, clk, rst_n, !(v1_reg && v2_reg && v3_reg) |-> in_ready, "pipe has a hole but refuses input")

endmodule

>>> rtl/lcc_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_matcher
// Eight parallel window compares against the cap-removal deltas, lowest wins.
// ----------------------------------------------------------------------------
module lcc_matcher (
    input  logic                                  clk,
    input  lcc_pkg::lcc_weights_t                 weights,
    input  logic signed [lcc_pkg::SCALED_BITS-1:0] scaled_delta,
    output lcc_pkg::lcc_match_t                   match
);
    import lcc_pkg::*;

    logic signed [BOUND_BITS-1:0] lo_reg   [NUM_COMBOS];
    logic signed [BOUND_BITS-1:0] hi_reg   [NUM_COMBOS];
    logic signed [BOUND_BITS-1:0] lo_next  [NUM_COMBOS];
    logic signed [BOUND_BITS-1:0] hi_next  [NUM_COMBOS];
    logic signed [BOUND_BITS-1:0] sum      [NUM_COMBOS];
    logic [NUM_COMBOS-1:0]        in_win;
    logic signed [BOUND_BITS-1:0] d_ext;
    logic signed [BOUND_BITS-1:0] m_ext;

    // Bounds are registered; user changes weights only while idle, unchecked.
    always_comb
    begin
        m_ext = BOUND_BITS'(weights.margin);
        for (int c = 0; c < NUM_COMBOS; c++)
        begin
            sum[c] = '0;
            if (((c >> 0) & 1) != 0)
                sum[c] = sum[c] + BOUND_BITS'(weights.cap1);
            if (((c >> 1) & 1) != 0)
                sum[c] = sum[c] + BOUND_BITS'(weights.cap2);
            if (((c >> 2) & 1) != 0)
                sum[c] = sum[c] + BOUND_BITS'(weights.cap3);
            lo_next[c] = -sum[c] - m_ext;
            hi_next[c] = m_ext - sum[c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COMBOS; c++)
        begin
            lo_reg[c] <= lo_next[c];
            hi_reg[c] <= hi_next[c];
        end
    end

    always_comb
    begin
        d_ext = BOUND_BITS'(scaled_delta);
        for (int c = 0; c < NUM_COMBOS; c++)
            in_win[c] = (d_ext >= lo_reg[c]) && (d_ext <= hi_reg[c]);

        match.found = |in_win;
        match.combo = '0;
        // walk down so the lowest hit is kept
        for (int c = NUM_COMBOS - 1; c >= 0; c--)
            if (in_win[c])
                match.combo = COMBO_BITS'(c);
    end

endmodule
